// ===== rtl/core/jbec_pkg.sv =====
`default_nettype none
package jbec_pkg;

  localparam int unsigned MaxMcuColumns = 319;
  localparam int unsigned MaxMcuRows    = 1050;
  localparam int unsigned TableSlots    = 4;
  localparam int unsigned MaxRes        = 6;

  typedef enum logic [1:0] {
    REQ_STREAM = 2'd0,
    REQ_COUNT  = 2'd1,
    REQ_SYMBOL = 2'd2,
    REQ_START  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_ROW_DONE  = 3'd1,
    ST_IMG_DONE  = 3'd2,
    ST_STREAM_ERR = 3'd3,
    ST_TABLE_ERR = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_DC_SYM = 3'd0,
    PH_DC_AMP = 3'd1,
    PH_AC_SYM = 3'd2,
    PH_AC_AMP = 3'd3,
    PH_PAD    = 3'd4,
    PH_MARKER = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    LD_IDLE    = 2'd0,
    LD_COUNTS  = 2'd1,
    LD_SYMBOLS = 2'd2
  } load_e;

  // top-level sequencer
  typedef enum logic [2:0] {
    SQ_IDLE   = 3'd0,
    SQ_LOOKUP = 3'd1,
    SQ_SYMBOL = 3'd2,
    SQ_FLUSH  = 3'd3,
    SQ_EMIT   = 3'd4
  } seq_e;

  localparam int unsigned RegMcusPerRow = 0;
  localparam int unsigned RegRetained   = 1;
  localparam int unsigned RegCompTables = 2;

  localparam logic [7:0] MarkerEoi = 8'hd9;
  localparam logic [7:0] MarkerRst = 8'hd0;
  localparam logic [7:0] SymZrl    = 8'hf0;

  typedef struct packed {
    logic [1:0] req_type;
    logic       table_class;
    logic [1:0] table_id;
    logic [7:0] entry_index;
    logic [7:0] data;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [2:0]  status;
    logic [10:0] rows_done;
    logic        last;
  } out_t;

  // lookup request from the decoder to the table store
  typedef struct packed {
    logic       en;
    logic [2:0] slot;
    logic [3:0] len_m1;
  } lkp_req_t;

  typedef struct packed {
    logic [8:0]  count;
    logic [15:0] first;
    logic [8:0]  offset;
  } lkp_ent_t;

endpackage
`default_nettype wire

// ===== rtl/core/jbec_tables.sv =====
`default_nettype none
// Huffman table store: per-length count/first/offset memory and symbol memory,
// both with a registered synchronous read.
module jbec_tables import jbec_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        ent_we_i,
  input  wire logic [6:0]  ent_waddr_i,
  input  wire lkp_ent_t    ent_wdata_i,
  input  wire logic        ent_re_i,
  input  wire logic [6:0]  ent_raddr_i,
  output lkp_ent_t         ent_rdata_o,
  input  wire logic        sym_we_i,
  input  wire logic [10:0] sym_waddr_i,
  input  wire logic [7:0]  sym_wdata_i,
  input  wire logic        sym_re_i,
  input  wire logic [10:0] sym_raddr_i,
  output logic [7:0]       sym_rdata_o
);

  lkp_ent_t   ent_mem [128];
  logic [7:0] sym_mem [2048];

  always_ff @(posedge clk_i) begin
    if (ent_we_i) ent_mem[ent_waddr_i] <= ent_wdata_i;
    if (ent_re_i) ent_rdata_o <= ent_mem[ent_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (sym_we_i) sym_mem[sym_waddr_i] <= sym_wdata_i;
    if (sym_re_i) sym_rdata_o <= sym_mem[sym_raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/jpeg_baseline_entropy_checker.sv =====
`default_nettype none
// Baseline 4:2:2 JPEG entropy checker with width crop. Load Huffman tables
// (sixteen count items then the symbols per table), issue a start-image item,
// then feed entropy-coded bytes. Table, control, pad and marker items go
// straight from taking the item to emitting its results. A data byte is
// walked bit by bit in SQ_FLUSH; each bit of a Huffman code also passes
// through SQ_LOOKUP for the table memory read, a finished code through
// SQ_SYMBOL for the symbol memory read, and a closing step checks the byte;
// an error ends the walk early. The table and symbol memories are read
// synchronously. Results appear one per cycle on the output while it is not
// stalled, last marking the final result of an item; no new item is taken
// until they drain.
module jpeg_baseline_entropy_checker import jbec_pkg::*; #(
  parameter int unsigned MAX_MCU_COLUMNS = MaxMcuColumns,
  parameter int unsigned MAX_MCU_ROWS    = MaxMcuRows,
  parameter int unsigned TABLE_SLOTS     = TableSlots
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o
);

  // configuration
  logic [8:0]  mpr_q, ret_q;
  logic [11:0] ctab_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpr_q  <= 9'd1;
      ret_q  <= '0;
      ctab_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        2'(RegMcusPerRow): mpr_q  <= cfg_data_i[8:0];
        2'(RegRetained):   ret_q  <= cfg_data_i[8:0];
        2'(RegCompTables): ctab_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [8:0] cols;
  always_comb begin
    if (mpr_q == '0) cols = 9'd1;
    else if (32'(mpr_q) > MAX_MCU_COLUMNS) cols = 9'(MAX_MCU_COLUMNS);
    else cols = mpr_q;
  end

  // state
  seq_e        sq_q, sq_d;
  in_t         it_q, it_d;
  logic [7:0]  bbuf_q, bbuf_d;
  logic [3:0]  bleft_q, bleft_d;
  logic        stuff_q, stuff_d;
  logic [15:0] cacc_q, cacc_d;
  logic [4:0]  clen_q, clen_d;
  phase_e      ph_q, ph_d;
  logic [10:0] aacc_q, aacc_d;
  logic [3:0]  abits_q, abits_d, asize_q, asize_d;
  logic [6:0]  cidx_q, cidx_d;
  logic [1:0]  blk_q, blk_d;
  logic [8:0]  col_q, col_d;
  logic [10:0] row_q, row_d;
  logic [10:0] dcp_q [3];
  logic [10:0] dcp_d [3];
  logic [7:0]  oacc_q, oacc_d;
  logic [3:0]  obc_q, obc_d;
  logic [7:0]  tpres_q, tpres_d;
  logic [16:0] lnc_q, lnc_d;
  logic [8:0]  lst_q, lst_d;
  load_e       lmode_q, lmode_d;
  logic [2:0]  lslot_q, lslot_d;
  logic [8:0]  lpos_q, lpos_d;
  logic [7:0]  rb_q [MaxRes];
  logic [7:0]  rb_d [MaxRes];
  logic [2:0]  rcnt_q, rcnt_d, ridx_q, ridx_d;
  logic [2:0]  stat_q, stat_d;
  logic        cur_bit_q, cur_bit_d;
  logic [7:0]  sym_q, sym_d;

  // memories
  logic        ent_we, ent_re, sym_we, sym_re;
  logic [6:0]  ent_waddr, ent_raddr;
  lkp_ent_t    ent_wdata, ent_rdata;
  logic [10:0] sym_waddr, sym_raddr;
  logic [7:0]  sym_wdata, sym_rdata;

  jbec_tables u_tables (
    .clk_i, .ent_we_i(ent_we), .ent_waddr_i(ent_waddr), .ent_wdata_i(ent_wdata),
    .ent_re_i(ent_re), .ent_raddr_i(ent_raddr), .ent_rdata_o(ent_rdata),
    .sym_we_i(sym_we), .sym_waddr_i(sym_waddr), .sym_wdata_i(sym_wdata),
    .sym_re_i(sym_re), .sym_raddr_i(sym_raddr), .sym_rdata_o(sym_rdata)
  );

  lkp_req_t lkp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= SQ_IDLE; bbuf_q <= '0; bleft_q <= '0; stuff_q <= 1'b0;
      cacc_q <= '0; clen_q <= '0; ph_q <= PH_DC_SYM; aacc_q <= '0;
      abits_q <= '0; asize_q <= '0; cidx_q <= '0; blk_q <= '0; col_q <= '0;
      row_q <= '0; dcp_q <= '{default: '0}; oacc_q <= '0; obc_q <= '0;
      tpres_q <= '0; lnc_q <= '0; lst_q <= '0; lmode_q <= LD_IDLE;
      lslot_q <= '0; lpos_q <= '0; rcnt_q <= '0; ridx_q <= '0; stat_q <= '0;
    end else begin
      sq_q <= sq_d; bbuf_q <= bbuf_d; bleft_q <= bleft_d; stuff_q <= stuff_d;
      cacc_q <= cacc_d; clen_q <= clen_d; ph_q <= ph_d; aacc_q <= aacc_d;
      abits_q <= abits_d; asize_q <= asize_d; cidx_q <= cidx_d; blk_q <= blk_d;
      col_q <= col_d; row_q <= row_d; dcp_q <= dcp_d; oacc_q <= oacc_d;
      obc_q <= obc_d; tpres_q <= tpres_d; lnc_q <= lnc_d; lst_q <= lst_d;
      lmode_q <= lmode_d; lslot_q <= lslot_d; lpos_q <= lpos_d;
      rcnt_q <= rcnt_d; ridx_q <= ridx_d; stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; rb_q <= rb_d; cur_bit_q <= cur_bit_d; sym_q <= sym_d;
  end

  // helpers as functions
  function automatic logic [7:0] stuffpad(input logic [7:0] acc, input logic [3:0] n);
    logic [7:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) if (4'(i) >= n) r = {r[6:0], 1'b1};
    return r;
  endfunction

  logic [1:0] comp;
  logic [3:0] csel;
  logic       ac_ph;
  logic [1:0] tid;
  logic [2:0] tslot;
  logic       nb;
  logic [15:0] cnext;
  logic [15:0] diff;
  logic       hit;

  always_comb begin
    comp  = (blk_q < 2'd2) ? 2'd0 : 2'(blk_q - 2'd1);
    csel  = ctab_q[4*comp +: 4];
    ac_ph = (ph_q == PH_AC_SYM);
    tid   = ac_ph ? csel[1:0] : csel[3:2];
    tslot = {ac_ph, tid};
    nb    = bbuf_q[bleft_q[2:0] - 3'd1];
    cnext = {cacc_q[14:0], cur_bit_q};
    diff  = cnext - ent_rdata.first;
    hit   = (cnext >= ent_rdata.first) && ({9'd0, diff} < {16'd0, ent_rdata.count});
  end

  always_comb begin
    // locals
    logic [8:0]  c9;
    logic [16:0] sum;
    logic [4:0]  len;
    logic        ok, eoi, bad;
    logic signed [12:0] p;
    logic signed [12:0] v;
    logic [7:0]  s;
    logic [7:0]  fb;
    logic [7:0]  nacc;
    logic [7:0]  rc;
    logic [6:0]  ci;

    sq_d = sq_q; it_d = it_q; bbuf_d = bbuf_q; bleft_d = bleft_q;
    stuff_d = stuff_q; cacc_d = cacc_q; clen_d = clen_q; ph_d = ph_q;
    aacc_d = aacc_q; abits_d = abits_q; asize_d = asize_q; cidx_d = cidx_q;
    blk_d = blk_q; col_d = col_q; row_d = row_q; dcp_d = dcp_q;
    oacc_d = oacc_q; obc_d = obc_q; tpres_d = tpres_q; lnc_d = lnc_q;
    lst_d = lst_q; lmode_d = lmode_q; lslot_d = lslot_q; lpos_d = lpos_q;
    rb_d = rb_q; rcnt_d = rcnt_q; ridx_d = ridx_q; stat_d = stat_q;
    cur_bit_d = cur_bit_q; sym_d = sym_q;
    ent_we = 1'b0; ent_waddr = '0; ent_wdata = '0;
    sym_we = 1'b0; sym_waddr = '0; sym_wdata = '0;
    lkp = '0; sym_re = 1'b0; sym_raddr = '0;
    in_stall_o = 1'b1;
    c9 = '0; sum = '0; len = '0; ok = 1'b0; eoi = 1'b0; bad = 1'b0;
    p = '0; v = '0; s = '0; fb = '0; nacc = '0; rc = '0; ci = '0;

    case (sq_q)
      SQ_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          it_d = in_data_i;
          rcnt_d = '0; ridx_d = '0; stat_d = ST_RUNNING;
          sq_d = SQ_EMIT;
          case (req_e'(in_data_i.req_type))
            REQ_START: begin
              dcp_d = '{default: '0}; cacc_d = '0; clen_d = '0; aacc_d = '0;
              abits_d = '0; asize_d = '0; cidx_d = '0; blk_d = '0; col_d = '0;
              oacc_d = '0; obc_d = '0; bbuf_d = '0; bleft_d = '0; stuff_d = 1'b0;
              ph_d = PH_DC_SYM; row_d = '0;
            end
            REQ_COUNT: begin
              if (32'(in_data_i.table_id) >= TABLE_SLOTS) begin
                stat_d = ST_TABLE_ERR; lmode_d = LD_IDLE;
              end else begin
                ok = 1'b1;
                lslot_d = {in_data_i.table_class, in_data_i.table_id};
                if (in_data_i.entry_index == '0) begin
                  if (tpres_q[{in_data_i.table_class, in_data_i.table_id}]) ok = 1'b0;
                  else begin
                    lmode_d = LD_COUNTS; lpos_d = '0; lnc_d = '0; lst_d = '0;
                  end
                end else if (lmode_q != LD_COUNTS || lslot_q != lslot_d
                             || {1'b0, in_data_i.entry_index} != lpos_q) begin
                  ok = 1'b0;
                end
                if (!ok) begin
                  stat_d = ST_TABLE_ERR; lmode_d = LD_IDLE; lslot_d = lslot_q;
                end else begin
                  c9 = {1'b0, in_data_i.data};
                  ent_we = 1'b1;
                  ent_waddr = {lslot_d, lpos_d[3:0]};
                  ent_wdata.count = c9;
                  ent_wdata.first = lnc_d[15:0];
                  ent_wdata.offset = lst_d;
                  len = 5'(lpos_d) + 5'd1;
                  sum = lnc_d + 17'(c9);
                  if (sum >= (17'd1 << len)) begin
                    stat_d = ST_TABLE_ERR; lmode_d = LD_IDLE;
                  end else begin
                    lnc_d = {sum[15:0], 1'b0};
                    lst_d = lst_d + c9;
                    if (lst_d > 9'd256 || (lst_d < lst_q && lmode_q == LD_COUNTS
                        && in_data_i.entry_index != '0)) begin
                      stat_d = ST_TABLE_ERR; lmode_d = LD_IDLE;
                    end else begin
                      lpos_d = lpos_d + 9'd1;
                      if (lpos_d == 9'd16) begin
                        if (lst_d == '0) begin
                          stat_d = ST_TABLE_ERR; lmode_d = LD_IDLE;
                        end else begin
                          lmode_d = LD_SYMBOLS; lpos_d = '0;
                        end
                      end
                    end
                  end
                end
              end
            end
            REQ_SYMBOL: begin
              s = in_data_i.data;
              if (32'(in_data_i.table_id) >= TABLE_SLOTS || lmode_q != LD_SYMBOLS
                  || lslot_q != {in_data_i.table_class, in_data_i.table_id}
                  || {1'b0, in_data_i.entry_index} != lpos_q) bad = 1'b1;
              else if (!in_data_i.table_class) bad = (s > 8'd11);
              else bad = (s[3:0] > 4'd10) || (s[3:0] == '0 && s != '0 && s != SymZrl);
              if (bad) begin
                stat_d = ST_TABLE_ERR; lmode_d = LD_IDLE;
              end else begin
                sym_we = 1'b1;
                sym_waddr = {lslot_q, lpos_q[7:0]};
                sym_wdata = s;
                lpos_d = lpos_q + 9'd1;
                if (lpos_d >= lst_q) begin
                  tpres_d[lslot_q] = 1'b1; lmode_d = LD_IDLE;
                end
              end
            end
            default: begin // stream byte
              if (ph_q == PH_ERROR || ph_q == PH_DONE) begin
                ph_d = PH_ERROR; stat_d = ST_STREAM_ERR;
              end else if (stuff_q) begin
                stuff_d = 1'b0;
                if (in_data_i.data != '0) begin
                  ph_d = PH_ERROR; stat_d = ST_STREAM_ERR;
                end
              end else if (ph_q == PH_PAD) begin
                if (in_data_i.data != 8'hff) begin
                  ph_d = PH_ERROR; stat_d = ST_STREAM_ERR;
                end else ph_d = PH_MARKER;
              end else if (ph_q == PH_MARKER) begin
                eoi = (in_data_i.data == MarkerEoi);
                if (!eoi && !(in_data_i.data == (MarkerRst | {5'd0, row_q[2:0]})
                    && 32'(row_q) + 1 < MAX_MCU_ROWS)) begin
                  ph_d = PH_ERROR; stat_d = ST_STREAM_ERR;
                end else begin
                  if (ret_q != '0) begin
                    if (obc_q != '0) begin
                      fb = stuffpad(oacc_q, obc_q);
                      rb_d[0] = fb; rc = 8'd1;
                      if (fb == 8'hff) begin rb_d[1] = '0; rc = 8'd2; end
                    end
                    rb_d[rc[2:0]] = 8'hff;
                    rb_d[rc[2:0] + 3'd1] = in_data_i.data;
                    rcnt_d = rc[2:0] + 3'd2;
                  end
                  oacc_d = '0; obc_d = '0;
                  row_d = row_q + 11'd1;
                  if (eoi) begin
                    ph_d = PH_DONE; stat_d = ST_IMG_DONE;
                  end else begin
                    dcp_d = '{default: '0}; cacc_d = '0; clen_d = '0; aacc_d = '0;
                    abits_d = '0; asize_d = '0; cidx_d = '0; blk_d = '0;
                    col_d = '0; bbuf_d = '0; bleft_d = '0; stuff_d = 1'b0;
                    ph_d = PH_DC_SYM; stat_d = ST_ROW_DONE;
                  end
                end
              end else begin
                bbuf_d = in_data_i.data; bleft_d = 4'd8;
                sq_d = SQ_FLUSH;
              end
            end
          endcase
        end
      end

      // bit walker: SQ_FLUSH takes the next bit
      SQ_FLUSH: begin
        if (ph_q == PH_ERROR) begin
          stat_d = ST_STREAM_ERR; bleft_d = '0; sq_d = SQ_EMIT;
        end else if (bleft_q == '0) begin
          if (bbuf_q == 8'hff) stuff_d = 1'b1;
          sq_d = SQ_EMIT;
        end else begin
          bleft_d = bleft_q - 4'd1;
          if (ph_q == PH_PAD) begin
            if (!nb) ph_d = PH_ERROR;
          end else begin
            // output packer
            if (col_q < ret_q) begin
              nacc = {oacc_q[6:0], nb};
              if (obc_q == 4'd7) begin
                rb_d[rcnt_q] = nacc; rc = {5'd0, rcnt_q} + 8'd1;
                if (nacc == 8'hff) begin rb_d[rc[2:0]] = '0; rc = rc + 8'd1; end
                rcnt_d = rc[2:0]; oacc_d = '0; obc_d = '0;
              end else begin
                oacc_d = nacc; obc_d = obc_q + 4'd1;
              end
            end
            case (ph_q)
              PH_DC_SYM, PH_AC_SYM: begin
                if (32'(tid) >= TABLE_SLOTS || !tpres_q[tslot]) ph_d = PH_ERROR;
                else begin
                  cur_bit_d = nb;
                  lkp.en = 1'b1; lkp.slot = tslot; lkp.len_m1 = clen_q[3:0];
                  sq_d = SQ_LOOKUP;
                end
              end
              PH_DC_AMP: begin
                aacc_d = {aacc_q[9:0], nb};
                abits_d = abits_q - 4'd1;
                if (abits_d == '0) begin
                  v = 13'(aacc_d);
                  if (aacc_d < (11'd1 << (asize_q - 4'd1)))
                    v = v - ((13'sd1 <<< asize_q) - 13'sd1);
                  p = 13'(signed'(dcp_q[comp])) + v;
                  if (p < -13'sd1024 || p > 13'sd1023) ph_d = PH_ERROR;
                  else begin
                    dcp_d[comp] = p[10:0]; cidx_d = 7'd1; ph_d = PH_AC_SYM;
                  end
                end
              end
              PH_AC_AMP: begin
                aacc_d = {aacc_q[9:0], nb};
                abits_d = abits_q - 4'd1;
                if (abits_d == '0) begin
                  cidx_d = cidx_q + 7'd1;
                  if (cidx_d >= 7'd64) begin
                    blk_d = blk_q + 2'd1; cidx_d = '0; ph_d = PH_DC_SYM;
                    if (blk_d == '0) begin
                      col_d = col_q + 9'd1;
                      if (col_d >= cols) ph_d = PH_PAD;
                    end
                  end else ph_d = PH_AC_SYM;
                end
              end
              default: ph_d = PH_ERROR;
            endcase
          end
        end
      end

      SQ_LOOKUP: begin
        cacc_d = cnext; clen_d = clen_q + 5'd1;
        sq_d = SQ_FLUSH;
        if (hit) begin
          sym_re = 1'b1;
          sym_raddr = {tslot, 8'(ent_rdata.offset + 9'(diff))};
          cacc_d = '0; clen_d = '0;
          sq_d = SQ_SYMBOL;
        end else if (clen_d >= 5'd16) ph_d = PH_ERROR;
      end

      SQ_SYMBOL: begin
        s = sym_rdata;
        sq_d = SQ_FLUSH;
        if (ph_q == PH_DC_SYM) begin
          if (s > 8'd11) ph_d = PH_ERROR;
          else if (s == '0) begin
            p = 13'(signed'(dcp_q[comp]));
            dcp_d[comp] = p[10:0]; cidx_d = 7'd1; ph_d = PH_AC_SYM;
          end else begin
            asize_d = s[3:0]; abits_d = s[3:0]; aacc_d = '0; ph_d = PH_DC_AMP;
          end
        end else begin
          ci = cidx_q;
          if (s == '0) begin
            blk_d = blk_q + 2'd1; cidx_d = '0; ph_d = PH_DC_SYM;
            if (blk_d == '0) begin
              col_d = col_q + 9'd1; if (col_d >= cols) ph_d = PH_PAD;
            end
          end else if (s == SymZrl) begin
            ci = cidx_q + 7'd16; cidx_d = ci;
            if (ci > 7'd64) ph_d = PH_ERROR;
            else if (ci == 7'd64) begin
              blk_d = blk_q + 2'd1; cidx_d = '0; ph_d = PH_DC_SYM;
              if (blk_d == '0) begin
                col_d = col_q + 9'd1; if (col_d >= cols) ph_d = PH_PAD;
              end
            end
          end else begin
            ci = cidx_q + {3'd0, s[7:4]}; cidx_d = ci;
            if (s[3:0] == '0 || s[3:0] > 4'd10 || ci >= 7'd64) ph_d = PH_ERROR;
            else begin
              asize_d = s[3:0]; abits_d = s[3:0]; aacc_d = '0; ph_d = PH_AC_AMP;
            end
          end
        end
      end

      SQ_EMIT: begin
        if (!out_stall_i) begin
          ridx_d = ridx_q + 3'd1;
          if (ridx_d >= rcnt_q) sq_d = SQ_IDLE;
        end
      end

      default: sq_d = SQ_IDLE;
    endcase
  end

  assign ent_re    = lkp.en;
  assign ent_raddr = {lkp.slot, lkp.len_m1};

  always_comb begin
    out_valid_o          = (sq_q == SQ_EMIT);
    out_data_o.out_valid = (rcnt_q != '0);
    out_data_o.out_byte  = (rcnt_q != '0) ? rb_q[ridx_q] : '0;
    out_data_o.status    = stat_q;
    out_data_o.rows_done = row_q;
    out_data_o.last      = (rcnt_q == '0) || (ridx_q + 3'd1 >= rcnt_q);
  end

endmodule
`default_nettype wire

// ===== rtl/core/jbec_checker.sv =====
`default_nettype none
module jbec_checker import jbec_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_TABLE_ERR)
    else $error("bad status");

  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |-> out_data_o.last)
    else $error("empty result not last");

endmodule

bind jpeg_baseline_entropy_checker jbec_checker u_jbec_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
`default_nettype wire
